// File: sv/lsts_pkg.sv
// Package for the longest-run-with-target-sum block.
// Sizes, the table entry layout and the controller state type; no dependencies.
`default_nettype none

package lsts_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);      // table address / stored index
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);  // counts up to MAX_ELEMENTS
  localparam int unsigned ELEM_W       = 16;
  localparam int unsigned SUM_W        = 32;
  localparam int unsigned LEN_W        = 11;

  // One first-occurrence table entry.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] sum;
  } ent_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic             dropped;
    logic [LEN_W-1:0] len;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: sv/lsts_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Standalone; no package needed.
`default_nettype none

module lsts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/lsts_ctrl.sv
// Controller: prefix sum, table scan over the first-occurrence RAM, best length.
// Depends on lsts_pkg and lsts_ram.
`default_nettype none

module lsts_ctrl
  import lsts_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ELEM_W-1:0] in_value_i,
  input  wire logic              in_last_i,
  input  wire logic [SUM_W-1:0]  target_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  state_e           state_q, state_d;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] best_q;
  logic [CNT_W-1:0] fill_q;
  logic             dropped_q;
  logic             last_q;
  logic [CNT_W-1:0] scan_addr_q;
  logic             rd_pend_q;
  logic             hit_a_q;
  logic             hit_b_q;
  logic [IDX_W-1:0] earlier_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  ent_t             ram_wdata;
  ent_t             ram_rdata;
  logic [SUM_W-1:0] key_a;
  logic             accept;
  logic             issue;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] head_len;

  lsts_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign issue    = (state_q == ST_SCAN) && (scan_addr_q != fill_q);
  assign key_a    = sum_q - target_i;
  assign head_len = idx_q + CNT_W'(1);
  assign run_len  = idx_q - CNT_W'(earlier_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (idx_q == CNT_W'(MAX_ELEMENTS)) begin
            state_d = in_last_i ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_addr_q == fill_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and RAM port
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    res_valid_o     = (state_q == ST_EMIT);
    res_o.len       = LEN_W'(best_q);
    res_o.dropped   = dropped_q;
    ram_we          = 1'b0;
    ram_addr        = scan_addr_q[IDX_W-1:0];
    ram_wdata.sum   = sum_q;
    ram_wdata.idx   = idx_q[IDX_W-1:0];
    case (state_q)
      ST_UPDATE: begin
        ram_addr = fill_q[IDX_W-1:0];
        ram_we   = !hit_b_q && (fill_q != CNT_W'(MAX_ELEMENTS));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      last_q      <= 1'b0;
      scan_addr_q <= '0;
      rd_pend_q   <= 1'b0;
      hit_a_q     <= 1'b0;
      hit_b_q     <= 1'b0;
      earlier_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q      <= in_last_i;
            scan_addr_q <= '0;
            rd_pend_q   <= 1'b0;
            hit_a_q     <= 1'b0;
            hit_b_q     <= 1'b0;
            if (idx_q == CNT_W'(MAX_ELEMENTS)) begin
              dropped_q <= 1'b1;
            end else begin
              sum_q <= sum_q + {{(SUM_W-ELEM_W){in_value_i[ELEM_W-1]}}, in_value_i};
            end
          end
        end
        ST_SCAN: begin
          rd_pend_q <= issue;
          if (issue) begin
            scan_addr_q <= scan_addr_q + CNT_W'(1);
          end
          // sums in the table are distinct, so a hit is the only hit
          if (rd_pend_q) begin
            if (ram_rdata.sum == key_a) begin
              hit_a_q   <= 1'b1;
              earlier_q <= ram_rdata.idx;
            end
            if (ram_rdata.sum == sum_q) begin
              hit_b_q <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          // a run from the start is always longer than any run after a stored prefix
          if (sum_q == target_i && head_len > best_q) begin
            best_q <= head_len;
          end else if (hit_a_q && run_len > best_q) begin
            best_q <= run_len;
          end
          if (ram_we) begin
            fill_q <= fill_q + CNT_W'(1);
          end
          idx_q <= head_len;
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            sum_q     <= '0;
            idx_q     <= '0;
            best_q    <= '0;
            fill_q    <= '0;
            dropped_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_fill_le_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= idx_q)
    else $error("table fill ahead of element count");

  a_idx_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count past capacity");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_addr_q <= fill_q))
    else $error("scan address past table fill");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_ready_i) |=> (idx_q == '0 && fill_q == '0 && !dropped_q))
    else $error("array state not cleared after result");

  a_write_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_UPDATE && !hit_b_q && fill_q < CNT_W'(MAX_ELEMENTS)))
    else $error("table write outside update or into a full table");

endmodule

`default_nettype wire

// File: sv/longest_subarray_with_target_sum.sv
// Top level: longest contiguous run whose sum equals a configured target.
// Depends on lsts_pkg and lsts_ctrl (which holds lsts_ram).
//
//   channel   dir  beat carries                         handshake
//   s_axis    in   element_value, is_last (tlast)       s_axis_tvalid_i / s_axis_tready_o
//   m_axis    out  longest_length, capacity_exceeded    m_axis_tvalid_o / m_axis_tready_i
//   cfg       in   target_sum                           cfg_valid_i / cfg_ready_o
//
// Sequence: an element is accepted, then one RAM read is issued per stored prefix
//   sum, then the update/write-back runs; the table scan through the single RAM port
//   sets the pace, and no new element is accepted until the update is done. A dropped
//   element is accepted without a scan. A last element then hands over its result.
// Reset: asynchronous, active low; target_sum returns to 0. The table RAM is not
//   cleared: only entries below the fill count are ever read.
// Stalls: the result sits in an output register, so the next array starts while it
//   waits; a second result waits in the controller until the register frees up.
`default_nettype none

module longest_subarray_with_target_sum
  import lsts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // element beats
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] element_value
  input  wire logic        s_axis_tlast_i,   // is_last
  // result beats
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [10:0] longest_length, [15:11] zero
  output logic [0:0]       m_axis_tuser_o,   // [0] capacity_exceeded
  // target_sum register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  logic [SUM_W-1:0] target_q;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  // target always ready; user writes only between arrays, nothing in flight; unenforced
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  lsts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .target_i    (target_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {{(16-LEN_W){1'b0}}, out_q.len};
  assign m_axis_tuser_o[0] = out_q.dropped;

endmodule

`default_nettype wire
